// ----- hdl/mtds_pkg.sv -----
// ----------------------------------------------------------------------------
// mtds_pkg
// Shared widths, constants and request/response types of the TDS converter.
// ----------------------------------------------------------------------------
package mtds_pkg;

  localparam int SAMPLE_COUNT_DEF = 32;

  localparam int SAMPLE_W = 10;
  localparam int REG_W    = 13;
  localparam int TDS_W    = 16;
  localparam int C_W      = 14;   // compensated millivolts
  localparam int K_W      = 15;   // temperature coefficient
  localparam int PROD_W   = 23;   // median times reference
  localparam int SCALED_W = 27;   // millivolts times 10000
  localparam int DVD_W    = 56;   // divider dividend and quotient
  localparam int DVS_W    = 38;   // divider divisor
  localparam int MUL_A_W  = 44;   // signed multiplicand
  localparam int MUL_P_W  = 58;   // signed product
  localparam int RECIP_W  = 43;   // reciprocal of 5^11 and its accumulator
  localparam int X_W      = 42;   // cubic over 2^12 below the saturation bound

  // Register indexes.
  localparam logic REG_REF_MV     = 1'b0;
  localparam logic REG_WATER_TEMP = 1'b1;

  localparam logic [REG_W-1:0] REF_MV_RST     = 13'd5000;
  localparam logic [REG_W-1:0] WATER_TEMP_RST = 13'd2500;

  localparam logic [K_W-1:0]            K_BASE      = 15'd5000;
  localparam logic [C_W-1:0]            SCALE_10K   = 14'd10000;
  localparam logic [C_W-1:0]            COEF_CUBE   = 14'd13342;
  localparam logic signed [MUL_A_W-1:0] COEF_SQUARE = 44'sd25586000;
  localparam logic signed [MUL_A_W-1:0] COEF_LIN    = 44'sd85739000000;

  // The final divisor 2*10^11 is 2^12 * 5^11. The multiplier is the ceiling of
  // 2^68 / 5^11, exact for every dividend below 65536 * 5^11.
  localparam logic [RECIP_W-1:0] RECIP_MUL = 43'd6044629098074;
  localparam logic [43:0]        SAT_LIMIT = 44'd3200000000000;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic [C_W-1:0]            b;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MUL_P_W-1:0] product;
  } mul_rsp_t;

endpackage

// ----- hdl/mtds_store.sv -----
// ----------------------------------------------------------------------------
// mtds_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtds_store #(
  parameter int DEPTH = mtds_pkg::SAMPLE_COUNT_DEF,
  parameter int AW    = 5
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [mtds_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [mtds_pkg::SAMPLE_W-1:0] rdata
);
  import mtds_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/mtds_div.sv -----
// ----------------------------------------------------------------------------
// mtds_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module mtds_div (
  input  logic               clk,
  input  logic               rst,
  input  mtds_pkg::div_req_t req,
  output mtds_pkg::div_rsp_t rsp
);
  import mtds_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  divisor;
  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W:0]    rem_sh;
  logic              geq;
  logic [DVS_W-1:0]  rem_next;

  // The remainder stays below the divisor, so dropping the top bit is safe.
  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign geq      = rem_sh >= {1'b0, divisor};
  assign rem_next = geq ? DVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        step    <= '0;
        dvd     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        rem  <= rem_next;
        quo  <= {quo[DVD_W-2:0], geq};
        dvd  <= dvd << 1;
        step <= step + 1'b1;
        if (step == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- hdl/mtds_mul.sv -----
// ----------------------------------------------------------------------------
// mtds_mul
// Shift-and-add multiplier: signed multiplicand, unsigned 14-bit multiplier.
// ----------------------------------------------------------------------------
module mtds_mul (
  input  logic               clk,
  input  logic               rst,
  input  mtds_pkg::mul_req_t req,
  output mtds_pkg::mul_rsp_t rsp
);
  import mtds_pkg::*;

  localparam int STEP_W = $clog2(C_W);

  logic                      busy;
  logic                      done;
  logic [STEP_W-1:0]         step;
  logic signed [MUL_P_W-1:0] acc;
  logic signed [MUL_P_W-1:0] a_sh;
  logic [C_W-1:0]            b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        acc  <= '0;
        a_sh <= {{(MUL_P_W - MUL_A_W){req.a[MUL_A_W-1]}}, req.a};
        b_sh <= req.b;
      end else if (busy) begin
        if (b_sh[0]) begin
          acc <= acc + a_sh;
        end
        a_sh <= a_sh <<< 1;
        b_sh <= b_sh >> 1;
        step <= step + 1'b1;
        if (step == STEP_W'(C_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

// ----- hdl/median_tds_converter.sv -----
// Computation: from the last sample of a batch to its result, mostly ten radix
//   passes over the store.
// Throughput: one sample per cycle while a batch fills; the input stalls during
//   the computation and while a result waits.
// Reset: fill count cleared, registers to 5000 mV and 25.00 C, no result.
// ----------------------------------------------------------------------------
// median_tds_converter
// Batch median of ADC samples by radix selection over the sample memory,
// followed by temperature compensation and the cubic TDS conversion.
// ----------------------------------------------------------------------------
module median_tds_converter #(
  parameter int SAMPLE_COUNT = mtds_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [mtds_pkg::REG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mtds_pkg::SAMPLE_W-1:0] adc_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mtds_pkg::TDS_W-1:0]    tds_ppm,
  output logic [mtds_pkg::SAMPLE_W-1:0] median_raw,
  output logic                          saturated
);
  import mtds_pkg::*;

  localparam int AW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int CW = $clog2(SAMPLE_COUNT + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SAMPLE_COUNT - 1);
  localparam logic [CW-1:0] K_LO = CW'((SAMPLE_COUNT - 1) / 2);
  localparam logic [CW-1:0] K_HI = CW'(SAMPLE_COUNT / 2);
  localparam logic [3:0]    TOP_BIT = 4'(SAMPLE_W - 1);
  localparam int            NUM_LO = 12;
  localparam int            Q_LO   = 26;

  typedef enum logic [9:0] {
    S_FILL  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_MV    = 10'b0000000100,
    S_SCALE = 10'b0000001000,
    S_DIV1  = 10'b0000010000,
    S_POLY  = 10'b0000100000,
    S_MUL2  = 10'b0001000000,
    S_MUL3  = 10'b0010000000,
    S_DIV2  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  logic [REG_W-1:0] ref_mv;
  logic [REG_W-1:0] water_temp;

  logic [AW-1:0]       fill_count;
  logic [AW-1:0]       rd_addr;
  logic                issuing;
  logic                rd_valid;
  logic                rd_last;
  logic [SAMPLE_W-1:0] rdata;
  logic [3:0]          bit_idx;
  logic [CW-1:0]       cnt_lo, cnt_hi, k_lo, k_hi;
  logic [SAMPLE_W-1:0] pre_lo, pre_hi;
  logic                launch;

  logic [SAMPLE_W-1:0]       median;
  logic [PROD_W-1:0]         prod;
  logic [SCALED_W-1:0]       scaled;
  logic [C_W-1:0]            cmv;
  logic signed [MUL_A_W-1:0] poly_a;
  logic [X_W-1:0]            rx;
  logic [RECIP_W-1:0]        racc;
  logic [5:0]                rstep;
  logic                      tds_sat;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic                in_acc;
  logic [SAMPLE_W:0]   low_ones;
  logic [SAMPLE_W-1:0] hi_mask;
  logic                hit_lo, hit_hi;
  logic [CW-1:0]       cnt_lo_sum, cnt_hi_sum;
  logic [SAMPLE_W:0]   med_sum;
  logic [K_W-1:0]      kcoef;
  logic [27:0]         cube_term;
  logic [RECIP_W:0]    racc_sum;

  assign in_stall = rst || (state != S_FILL);
  assign in_acc   = in_valid && !in_stall;

  mtds_store #(.DEPTH(SAMPLE_COUNT), .AW(AW)) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (fill_count),
    .wdata (adc_sample),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // A sample counts for a selector when it shares the prefix found so far
  // and has a zero in the bit under test.
  assign low_ones   = (11'(2) << bit_idx) - 11'(1);
  assign hi_mask    = ~low_ones[SAMPLE_W-1:0];
  assign hit_lo     = (((rdata ^ pre_lo) & hi_mask) == '0) && !rdata[bit_idx];
  assign hit_hi     = (((rdata ^ pre_hi) & hi_mask) == '0) && !rdata[bit_idx];
  assign cnt_lo_sum = cnt_lo + CW'(hit_lo);
  assign cnt_hi_sum = cnt_hi + CW'(hit_hi);

  assign med_sum   = {1'b0, pre_lo} + {1'b0, pre_hi};
  assign kcoef     = K_BASE + K_W'({water_temp, 1'b0});
  assign cube_term = 28'(COEF_CUBE) * 28'(cmv);

  // Serial reciprocal multiply, least significant bit first; the accumulator
  // keeps only the bits above those already shifted out.
  assign racc_sum = {1'b0, racc} + {1'b0, (rx[0] ? RECIP_MUL : '0)};

  assign div_req.start    = launch && (state == S_DIV1);
  assign div_req.dividend = DVD_W'(scaled);
  assign div_req.divisor  = DVS_W'(kcoef);

  assign mul_req.start = launch && ((state == S_MUL2) || (state == S_MUL3));
  assign mul_req.a     = poly_a;
  assign mul_req.b     = cmv;

  mtds_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mtds_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mv     <= REF_MV_RST;
      water_temp <= WATER_TEMP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_REF_MV:     ref_mv     <= cfg_data;
        REG_WATER_TEMP: water_temp <= cfg_data;
        default:        ref_mv     <= ref_mv;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill_count <= '0;
      issuing    <= 1'b0;
      rd_valid   <= 1'b0;
      rd_last    <= 1'b0;
      launch     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      launch   <= 1'b0;
      rd_valid <= issuing;
      rd_last  <= issuing && (rd_addr == LAST_ADDR);
      if (issuing) begin
        if (rd_addr == LAST_ADDR) begin
          issuing <= 1'b0;
        end else begin
          rd_addr <= rd_addr + 1'b1;
        end
      end
      if ((state == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_FILL: begin
          if (in_acc) begin
            if (fill_count == LAST_ADDR) begin
              fill_count <= '0;
              pre_lo     <= '0;
              pre_hi     <= '0;
              k_lo       <= K_LO;
              k_hi       <= K_HI;
              cnt_lo     <= '0;
              cnt_hi     <= '0;
              bit_idx    <= TOP_BIT;
              issuing    <= 1'b1;
              rd_addr    <= '0;
              state      <= S_SCAN;
            end else begin
              fill_count <= fill_count + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (rd_valid) begin
            if (rd_last) begin
              cnt_lo <= '0;
              cnt_hi <= '0;
              if (k_lo >= cnt_lo_sum) begin
                pre_lo <= pre_lo | (SAMPLE_W'(1) << bit_idx);
                k_lo   <= k_lo - cnt_lo_sum;
              end
              if (k_hi >= cnt_hi_sum) begin
                pre_hi <= pre_hi | (SAMPLE_W'(1) << bit_idx);
                k_hi   <= k_hi - cnt_hi_sum;
              end
              if (bit_idx == 4'd0) begin
                state <= S_MV;
              end else begin
                bit_idx <= bit_idx - 1'b1;
                issuing <= 1'b1;
                rd_addr <= '0;
              end
            end else begin
              cnt_lo <= cnt_lo_sum;
              cnt_hi <= cnt_hi_sum;
            end
          end
        end
        S_MV: begin
          median <= med_sum[SAMPLE_W:1];
          prod   <= PROD_W'(med_sum[SAMPLE_W:1]) * PROD_W'(ref_mv);
          state  <= S_SCALE;
        end
        S_SCALE: begin
          scaled <= SCALED_W'(prod[PROD_W-1:10]) * SCALED_W'(SCALE_10K);
          launch <= 1'b1;
          state  <= S_DIV1;
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            cmv   <= div_rsp.quotient[C_W-1:0];
            state <= S_POLY;
          end
        end
        S_POLY: begin
          poly_a <= signed'(MUL_A_W'(cube_term)) - COEF_SQUARE;
          launch <= 1'b1;
          state  <= S_MUL2;
        end
        S_MUL2: begin
          if (mul_rsp.done) begin
            poly_a <= mul_rsp.product[MUL_A_W-1:0] + COEF_LIN;
            launch <= 1'b1;
            state  <= S_MUL3;
          end
        end
        S_MUL3: begin
          if (mul_rsp.done) begin
            // The cubic is positive for every positive input. Its low
            // twelve bits never reach the quotient.
            rx      <= mul_rsp.product[X_W+NUM_LO-1:NUM_LO];
            tds_sat <= mul_rsp.product[DVD_W-1:NUM_LO] >= SAT_LIMIT;
            racc    <= '0;
            rstep   <= '0;
            state   <= S_DIV2;
          end
        end
        S_DIV2: begin
          racc  <= racc_sum[RECIP_W:1];
          rx    <= rx >> 1;
          rstep <= rstep + 1'b1;
          if (rstep == 6'(X_W - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            tds_ppm    <= tds_sat ? '1 : racc[Q_LO+TDS_W-1:Q_LO];
            saturated  <= tds_sat;
            median_raw <= median;
            state      <= S_FILL;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= LAST_ADDR)
    else $error("fill count beyond the batch size");

  a_prefix_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_MV) |-> (pre_lo <= pre_hi))
    else $error("lower middle sample above upper middle sample");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (tds_ppm == '1))
    else $error("saturated result not clamped");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (issuing || rd_valid) |-> !in_acc)
    else $error("sample written during a memory scan");

endmodule

// ----- sim/tb_median_tds_converter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_median_tds_converter
// Sends batches of ADC samples, predicts the median and the compensated TDS of
// each batch without a typed expectation, and checks every result against its expectation in order.
// ----------------------------------------------------------------------------
module tb_median_tds_converter;
  import mtds_pkg::*;

  localparam int BATCH       = SAMPLE_COUNT_DEF;
  localparam int SETTLE_CYC  = 600;
  localparam int RAND_BATCHES = 22;

  typedef struct {
    logic [TDS_W-1:0]    tds;
    logic [SAMPLE_W-1:0] median;
    logic                sat;
  } tds_result_t;

  typedef struct {
    logic [REG_W-1:0]    ref_mv;
    logic [REG_W-1:0]    temp;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    bit                  typed;
    tds_result_t         res;
  } batch_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = REG_REF_MV;
  logic [REG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] adc_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [TDS_W-1:0]    tds_ppm;
  logic [SAMPLE_W-1:0] median_raw;
  logic                saturated;

  median_tds_converter dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [REG_W-1:0]    cur_ref_mv = REF_MV_RST;
  logic [REG_W-1:0]    cur_temp   = WATER_TEMP_RST;
  logic [SAMPLE_W-1:0] batch_buf[BATCH];
  int                  batch_fill = 0;
  tds_result_t         pending_results[$];

  int  err_cnt = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  sat_seen = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cycles = 0;

  function automatic logic [SAMPLE_W-1:0] batch_median();
    int sorted[$];
    for (int i = 0; i < BATCH; i++) sorted.push_back(int'(batch_buf[i]));
    sorted.sort();
    if (BATCH % 2) return SAMPLE_W'(sorted[(BATCH - 1) / 2]);
    return SAMPLE_W'((sorted[BATCH / 2] + sorted[BATCH / 2 - 1]) / 2);
  endfunction

  function automatic tds_result_t convert_median(logic [SAMPLE_W-1:0] med);
    longint unsigned mv, k, c, pos, neg, t;
    tds_result_t r;
    mv  = (64'(med) * 64'(cur_ref_mv)) / 64'd1024;
    k   = 64'd5000 + 64'd2 * 64'(cur_temp);
    c   = (mv * 64'd10000) / k;
    pos = 64'd13342 * c * c * c + 64'd85739000000 * c;
    neg = 64'd25586000 * c * c;
    t   = (pos < neg) ? 64'd0 : (pos - neg) / 64'd200000000000;
    r.median = med;
    r.sat    = (t > 64'd65535);
    r.tds    = r.sat ? 16'hFFFF : TDS_W'(t);
    return r;
  endfunction

  // Sends one sample and returns once the transaction has been accepted.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v, output bit done_batch);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= v;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    batch_buf[batch_fill] = v;
    batch_fill++;
    done_batch = (batch_fill == BATCH);
    if (done_batch) batch_fill = 0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_REF_MV) cur_ref_mv = val;
    else cur_temp = val;
  endtask

  task automatic set_regs(input logic [REG_W-1:0] ref_mv, input logic [REG_W-1:0] temp);
    if (ref_mv == cur_ref_mv && temp == cur_temp) return;
    wait_idle();
    write_reg(REG_REF_MV, ref_mv);
    write_reg(REG_WATER_TEMP, temp);
    cfg_wr_en <= 1'b0;
  endtask

  // Sends a whole batch; a typed expectation replaces the predicted one.
  task automatic send_batch(input logic [SAMPLE_W-1:0] vals[BATCH], input bit typed,
                            input tds_result_t typed_res);
    bit done;
    for (int i = 0; i < BATCH; i++) begin
      send_sample(vals[i], done);
      if (done) pending_results.push_back(typed ? typed_res : convert_median(batch_median()));
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_stall   <= 1'b1;
      hold_cycles <= 1999;
      hold_done   <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: tds %0d median %0d sat %0d",
                 $time, tds_ppm, median_raw, saturated);
        err_cnt++;
      end else begin
        tds_result_t e;
        e = pending_results.pop_front();
        results_seen++;
        if (saturated) sat_seen++;
        if (tds_ppm !== e.tds) begin
          $display("%0t: tds_ppm expected %0d actual %0d", $time, e.tds, tds_ppm);
          err_cnt++;
        end
        if (median_raw !== e.median) begin
          $display("%0t: median_raw expected %0d actual %0d", $time, e.median, median_raw);
          err_cnt++;
        end
        if (saturated !== e.sat) begin
          $display("%0t: saturated expected %0d actual %0d", $time, e.sat, saturated);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    batch_row_t          rows[$];
    batch_row_t          r;
    logic [SAMPLE_W-1:0] vals[BATCH];
    logic [SAMPLE_W-1:0] centre;
    int                  kind;
    int                  guard;

    // Directed batches: half lo, half hi, so the median is the truncated mean.
    rows.push_back('{REF_MV_RST, WATER_TEMP_RST, 10'd0, 10'd0, 1, '{16'd0, 10'd0, 1'b0}});
    rows.push_back('{REF_MV_RST, WATER_TEMP_RST, 10'd1023, 10'd1023, 0, '{0, 0, 0}});
    rows.push_back('{13'd8191, 13'd0, 10'd1023, 10'd1023, 1, '{16'hFFFF, 10'd1023, 1'b1}});
    rows.push_back('{13'd0, 13'd8191, 10'd1023, 10'd1023, 1, '{16'd0, 10'd1023, 1'b0}});
    rows.push_back('{13'd1000, 13'd5000, 10'd0, 10'd1023, 0, '{0, 0, 0}});
    rows.push_back('{13'd5500, 13'd0, 10'd1022, 10'd1023, 0, '{0, 0, 0}});
    rows.push_back('{13'd5000, 13'd2500, 10'h2AA, 10'h155, 0, '{0, 0, 0}});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[n]) begin
      r = rows[n];
      set_regs(r.ref_mv, r.temp);
      for (int i = 0; i < BATCH; i++) vals[i] = (i % 2) ? r.hi : r.lo;
      send_batch(vals, r.typed, r.res);
    end

    for (int b = 0; b < RAND_BATCHES; b++) begin
      if (b % 4 == 3) begin
        if ($urandom_range(0, 1))
          set_regs(REG_W'($urandom_range(1000, 5500)), REG_W'($urandom_range(0, 5000)));
        else
          set_regs(REG_W'($urandom), REG_W'($urandom));
      end
      // Long hold-off so the result backs up and the input stalls.
      if (b == 5) hold_req = 1'b1;
      if (b >= RAND_BATCHES - 5) quiet = 1'b1;
      kind   = $urandom_range(0, 3);
      centre = SAMPLE_W'($urandom);
      for (int i = 0; i < BATCH; i++) begin
        case (kind)
          0: vals[i] = SAMPLE_W'($urandom);
          1: vals[i] = SAMPLE_W'(int'(centre) + $urandom_range(0, 16) - 8);
          2: vals[i] = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
          default: vals[i] = SAMPLE_W'(i * 33 + int'(centre));
        endcase
      end
      send_batch(vals, 0, '{0, 0, 0});
    end
    in_valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      err_cnt++;
    end

    $display("Covered %0d samples in %0d checked batches, %0d of them saturated,",
             samples_sent, results_seen, sat_seen);
    $display("across reset, extreme and random reference and temperature settings.");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- median_tds_converter.f -----
hdl/mtds_pkg.sv
hdl/mtds_store.sv
hdl/mtds_div.sv
hdl/mtds_mul.sv
hdl/median_tds_converter.sv
sim/tb_median_tds_converter.sv
